@@ rtl/aarm_pkg.sv @@
package aarm_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int FRAC_BITS     = 30;

  localparam int IN_W   = 128;
  localparam int OUT_W  = 288;

  // pipeline stage map
  localparam int NRM_FIRST  = 3;
  localparam int NRM_STEPS  = 5;
  localparam int CRD_FIRST  = 4;
  localparam int SQRT_FIRST = NRM_FIRST + NRM_STEPS;
  localparam int SQRT_BITS  = 32;
  localparam int DIV_FIRST  = SQRT_FIRST + SQRT_BITS;
  localparam int DIV_BITS   = 31;
  localparam int MAT_FIRST  = DIV_FIRST + DIV_BITS;
  localparam int NSTAGE     = MAT_FIRST + 3;

  localparam logic signed [35:0] ONE_Q30   = 36'sd1073741824;
  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
  localparam logic signed [33:0] ANG_BIAS  = 34'sd2170552320; // 92 turns
  localparam logic signed [25:0] DEG_90    = 26'sd5898240;
  localparam logic signed [25:0] DEG_180   = 26'sd11796480;
  localparam logic signed [25:0] DEG_360   = 26'sd23592960;
  localparam logic signed [53:0] RAD_Q32   = 54'sd74961321;

  typedef struct packed {
    logic              zero;
    logic [2:0]        sgn;
    logic [2:0][31:0]  mag;
    logic [2:0][63:0]  sq;
    logic [63:0]       nrm;
    logic [4:0]        k;
    logic [35:0]       srem;
    logic [31:0]       root;
    logic [2:0][32:0]  drem;
    logic [2:0][30:0]  dlo;
    logic [2:0][30:0]  quo;
    logic [13:0]       ah;
    logic [18:0]       alo;
    logic [8:0]        aq;
    logic [25:0]       ared;
    logic              aneg;
    logic [33:0]       cx;
    logic [33:0]       cy;
    logic [32:0]       cz;
    logic [2:0][34:0]  pd;
    logic [2:0][34:0]  po;
    logic [2:0][34:0]  sp;
    logic [34:0]       cc;
    logic [34:0]       tt;
    logic [8:0][35:0]  msum;
    logic [8:0][31:0]  res;
  } pipe_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] a;
    case (i)
      0: a = 30'd843314856;   1: a = 30'd497837829;   2: a = 30'd263043836;
      3: a = 30'd133525158;   4: a = 30'd67021686;    5: a = 30'd33543515;
      6: a = 30'd16775850;    7: a = 30'd8388437;     8: a = 30'd4194282;
      9: a = 30'd2097149;    10: a = 30'd1048575;    11: a = 30'd524287;
      12: a = 30'd262143;    13: a = 30'd131071;     14: a = 30'd65535;
      15: a = 30'd32767;     16: a = 30'd16383;      17: a = 30'd8191;
      18: a = 30'd4095;      19: a = 30'd2047;       20: a = 30'd1023;
      21: a = 30'd511;       22: a = 30'd255;        23: a = 30'd127;
      24: a = 30'd63;        25: a = 30'd31;         26: a = 30'd15;
      27: a = 30'd8;         28: a = 30'd4;          29: a = 30'd2;
      30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // round half away from zero
  function automatic logic signed [69:0] rnd_shift(input logic signed [69:0] v, input int n);
    logic signed [69:0] half;
    logic signed [69:0] r;
    half = 70'sd0;
    r = v;
    if (n > 0) begin
      half = 70'sd1 <<< (n - 1);
      if (v >= 0) r = (v + half) >>> n;
      else r = -((-v + half) >>> n);
    end
    return r;
  endfunction

  function automatic logic signed [34:0] qmul(input logic signed [34:0] a,
                                              input logic signed [34:0] b);
    logic signed [69:0] pr;
    logic signed [69:0] r;
    pr = a * b;
    r = rnd_shift(pr, 30);
    return r[34:0];
  endfunction

  function automatic logic signed [35:0] clamp1(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = v;
    if (v > ONE_Q30) r = ONE_Q30;
    else if (v < -ONE_Q30) r = -ONE_Q30;
    return r;
  endfunction

endpackage

@@ rtl/axis_angle_rotation_matrix.sv @@
// channel | ports                        | beat contents
// in      | in_tvalid/in_tready/in_tdata | angle_deg, axis_x, axis_y, axis_z
// out     | out_tvalid/out_tready/out_*  | r00..r22 in tdata, zero_axis in tuser
//
// One beat per cycle sustained unless the output buffer fills; a 74 stage
// pipeline of shared enable feeds a 2-entry output buffer. The length is set
// by the 32-step square root and the 31-step restoring dividers on the axis path.
// Reset clears stage valids and the output buffer. When the buffer is full the
// whole pipeline holds; in_tready never depends on out_tready combinationally.
module axis_angle_rotation_matrix (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [aarm_pkg::IN_W-1:0]     in_tdata,   // angle_deg, axis_x, axis_y, axis_z
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [aarm_pkg::OUT_W-1:0]    out_tdata,  // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic                          out_tuser   // zero_axis
);
  import aarm_pkg::*;

  pipe_t              st_r   [NSTAGE];
  pipe_t              st_nxt [NSTAGE];
  logic [NSTAGE-1:0]  v_r;
  logic [OUT_W:0]     buf_r  [2];
  logic               wptr_r;
  logic               rptr_r;
  logic [1:0]         cnt_r;
  logic               en;
  logic               push;
  logic               pop;

  function automatic pipe_t stage_fn(input int j, input pipe_t p);
    pipe_t              o;
    logic [13:0]        hr;
    logic [24:0]        rdeg;
    logic signed [25:0] rs;
    logic signed [69:0] th;
    logic signed [33:0] x0, y0, dx, dy;
    logic signed [32:0] z0;
    logic signed [32:0] at;
    logic [35:0]        rsh;
    logic [35:0]        trial;
    logic [31:0]        rt;
    logic [93:0]        dd;
    logic [32:0]        dr;
    logic [32:0]        dq;
    logic [30:0]        dl;
    logic signed [34:0] u [3];
    logic signed [34:0] c, s, oxy, oxz, oyz;
    logic signed [35:0] cv, sv, mv;
    logic signed [69:0] rr;
    int                 sh;
    int                 ci;
    o = p;
    if (j == 1) begin
      for (int i = 0; i < 3; i++) o.sq[i] = p.mag[i] * p.mag[i];
      o.aq = 9'((25'(p.ah) * 25'd1456) >> 16);
    end
    if (j == 2) begin
      o.nrm = p.sq[0] + p.sq[1] + p.sq[2];
      o.k = 5'd0;
      hr = p.ah - 14'(p.aq * 14'd45);
      if (hr >= 14'd45) hr = hr - 14'd45;
      rdeg = {hr[5:0], p.alo};
      rs = $signed({1'b0, rdeg});
      if (rs >= DEG_180) rs = rs - DEG_360;
      o.aneg = 1'b0;
      if (rs > DEG_90) begin
        rs = rs - DEG_180;
        o.aneg = 1'b1;
      end else if (rs < -DEG_90) begin
        rs = rs + DEG_180;
        o.aneg = 1'b1;
      end
      o.ared = rs;
    end
    if (j == 3) begin
      th = 70'($signed(p.ared)) * 70'(RAD_Q32);
      th = rnd_shift(th, 18);
      o.cz = th[32:0];
    end
    if (j >= NRM_FIRST && j < NRM_FIRST + NRM_STEPS) begin
      sh = 32 >> (j - NRM_FIRST);
      if ((p.nrm >> (64 - sh)) == 64'd0) begin
        o.nrm = p.nrm << sh;
        o.k = p.k + 5'(sh >> 1);
      end
    end
    if (j >= CRD_FIRST && j < CRD_FIRST + CORDIC_STAGES) begin
      ci = j - CRD_FIRST;
      if (j == CRD_FIRST) begin
        x0 = GAIN_Q30;
        y0 = 34'sd0;
      end else begin
        x0 = $signed(p.cx);
        y0 = $signed(p.cy);
      end
      z0 = $signed(p.cz);
      dx = y0 >>> ci;
      dy = x0 >>> ci;
      at = $signed({3'b000, atan_q30(ci)});
      if (z0 >= 0) begin
        o.cx = x0 - dx;
        o.cy = y0 + dy;
        o.cz = z0 - at;
      end else begin
        o.cx = x0 + dx;
        o.cy = y0 - dy;
        o.cz = z0 + at;
      end
    end
    if (j >= SQRT_FIRST && j < SQRT_FIRST + SQRT_BITS) begin
      if (j == SQRT_FIRST) begin
        rsh = 36'd0;
        rt = 32'd0;
      end else begin
        rsh = p.srem;
        rt = p.root;
      end
      rsh = {rsh[33:0], p.nrm[63:62]};
      trial = {2'b00, rt, 2'b01};
      o.nrm = p.nrm << 2;
      if (rsh >= trial) begin
        o.srem = rsh - trial;
        o.root = {rt[30:0], 1'b1};
      end else begin
        o.srem = rsh;
        o.root = {rt[30:0], 1'b0};
      end
    end
    if (j >= DIV_FIRST && j < DIV_FIRST + DIV_BITS) begin
      dq = {1'b0, p.root};
      for (int i = 0; i < 3; i++) begin
        if (j == DIV_FIRST) begin
          dd = ((94'(p.mag[i]) << p.k) << 30) + 94'(p.root >> 1);
          dr = dd[63:31];
          dl = dd[30:0];
        end else begin
          dr = p.drem[i];
          dl = p.dlo[i];
        end
        dr = {dr[31:0], dl[30]};
        o.dlo[i] = {dl[29:0], 1'b0};
        if (dr >= dq) begin
          o.drem[i] = dr - dq;
          o.quo[i] = {p.quo[i][29:0], 1'b1};
        end else begin
          o.drem[i] = dr;
          o.quo[i] = {p.quo[i][29:0], 1'b0};
        end
      end
    end
    if (j == MAT_FIRST) begin
      for (int i = 0; i < 3; i++) begin
        u[i] = p.sgn[i] ? -$signed({4'b0000, p.quo[i]}) : $signed({4'b0000, p.quo[i]});
      end
      cv = 36'($signed(p.cx));
      sv = 36'($signed(p.cy));
      cv = clamp1(p.aneg ? -cv : cv);
      sv = clamp1(p.aneg ? -sv : sv);
      c = cv[34:0];
      s = sv[34:0];
      for (int i = 0; i < 3; i++) begin
        o.pd[i] = qmul(u[i], u[i]);
        o.sp[i] = qmul(u[i], s);
      end
      o.po[0] = qmul(u[0], u[1]);
      o.po[1] = qmul(u[0], u[2]);
      o.po[2] = qmul(u[1], u[2]);
      o.cc = c;
      o.tt = 35'(ONE_Q30) - c;
    end
    if (j == MAT_FIRST + 1) begin
      for (int i = 0; i < 3; i++) begin
        o.msum[4*i] = 36'($signed(p.pd[i]))
                    + 36'(qmul(35'(ONE_Q30) - $signed(p.pd[i]), $signed(p.cc)));
      end
      oxy = qmul($signed(p.po[0]), $signed(p.tt));
      oxz = qmul($signed(p.po[1]), $signed(p.tt));
      oyz = qmul($signed(p.po[2]), $signed(p.tt));
      o.msum[1] = 36'(oxy) - 36'($signed(p.sp[2]));
      o.msum[3] = 36'(oxy) + 36'($signed(p.sp[2]));
      o.msum[2] = 36'(oxz) + 36'($signed(p.sp[1]));
      o.msum[6] = 36'(oxz) - 36'($signed(p.sp[1]));
      o.msum[5] = 36'(oyz) - 36'($signed(p.sp[0]));
      o.msum[7] = 36'(oyz) + 36'($signed(p.sp[0]));
    end
    if (j == MAT_FIRST + 2) begin
      for (int i = 0; i < 9; i++) begin
        if (p.zero) mv = (i % 4 == 0) ? ONE_Q30 : 36'sd0;
        else mv = clamp1($signed(p.msum[i]));
        rr = rnd_shift(70'(mv), 30 - FRAC_BITS);
        o.res[i] = rr[31:0];
      end
    end
    return o;
  endfunction

  always_comb begin
    logic signed [33:0] a34;
    logic signed [31:0] v;
    st_nxt[0] = '0;
    for (int i = 0; i < 3; i++) begin
      v = $signed(in_tdata[32*(i+1) +: 32]);
      st_nxt[0].sgn[i] = v[31];
      st_nxt[0].mag[i] = v[31] ? 32'(-v) : 32'(v);
    end
    st_nxt[0].zero = (in_tdata[127:32] == 96'd0);
    a34 = 34'($signed(in_tdata[31:0])) + ANG_BIAS;
    st_nxt[0].ah = a34[32:19];
    st_nxt[0].alo = a34[18:0];
  end

  for (genvar j = 1; j < NSTAGE; j++) begin : g_st
    always_comb st_nxt[j] = stage_fn(j, st_r[j-1]);
  end

  assign en = (cnt_r != 2'd2);
  assign in_tready = en;
  assign push = en && v_r[NSTAGE-1];
  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTAGE-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NSTAGE; j++) st_r[j] <= st_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wptr_r] <= {st_r[NSTAGE-1].zero, st_r[NSTAGE-1].res};
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf_r[rptr_r][OUT_W-1:0];
  assign out_tuser  = buf_r[rptr_r][OUT_W];

endmodule

@@ tb/axis_angle_rotation_matrix_tb.sv @@
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_tb;
  import aarm_pkg::*;

  localparam int LATENCY = 75;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM = 2000;
  localparam longint Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [31:0] az;
    logic [31:0] ay;
    logic [31:0] ax;
    logic [31:0] ang;
  } rot_req_t;

  typedef struct {
    logic [8:0][31:0] m;
    logic             zero;
  } rot_mat_t;

  typedef struct {
    rot_req_t req;
    bit       typed;
    rot_mat_t mat;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [127:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [287:0] out_tdata;
  logic out_tuser;

  rot_mat_t mat_q[$];
  int errors;
  int idle_cycles;
  bit send_done;

  axis_angle_rotation_matrix i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat_one(longint v);
    if (v > Q30) return Q30;
    if (v < -Q30) return -Q30;
    return v;
  endfunction

  function automatic longint rnd_away(longint v, int n);
    longint h;
    if (n == 0) return v;
    h = longint'(1) << (n - 1);
    if (v >= 0) return (v + h) >>> n;
    return -((-v + h) >>> n);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return rnd_away(a * b, 30);
  endfunction

  function automatic longint asr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint atan_step(int i);
    longint t[32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
      31, 15, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned num);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > num) b >>= 2;
    while (b != 0) begin
      if (num >= res + b) begin
        num -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint v, int k, longint unsigned q);
    longint unsigned mag, num;
    longint r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    num = (mag << k) << 30;
    r = longint'((num + (q >> 1)) / q);
    return sat_one(v < 0 ? -r : r);
  endfunction

  function automatic rot_mat_t rotation_matrix(rot_req_t rq);
    rot_mat_t o;
    longint ang, vx, vy, vz, ux, uy, uz, r, th, x, y, z, c, s, t, p, dx, dy;
    longint e[9];
    longint unsigned s2, q;
    int k;
    bit neg;
    ang = longint'(signed'(rq.ang));
    vx = longint'(signed'(rq.ax));
    vy = longint'(signed'(rq.ay));
    vz = longint'(signed'(rq.az));
    s2 = vx * vx + vy * vy + vz * vz;
    neg = 0;
    if (s2 == 0) begin
      for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? Q30 : 0;
    end else begin
      k = 0;
      while (k < 31 && (s2 << (2 * k)) < (64'd1 << 62) &&
             ((s2 << (2 * k)) >> (2 * k)) == s2)
        k++;
      q = int_sqrt(s2 << (2 * k));
      ux = unit_part(vx, k, q);
      uy = unit_part(vy, k, q);
      uz = unit_part(vz, k, q);
      r = ang % (longint'(360) << 16);
      if (r < 0) r += longint'(360) << 16;
      if (r >= (longint'(180) << 16)) r -= longint'(360) << 16;
      if (r > (longint'(90) << 16)) begin
        r -= longint'(180) << 16;
        neg = 1;
      end else if (r < -(longint'(90) << 16)) begin
        r += longint'(180) << 16;
        neg = 1;
      end
      th = rnd_away(r * 74961321, 18);
      x = 652032874;
      y = 0;
      z = th;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        dx = asr_floor(y, i);
        dy = asr_floor(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_step(i);
        end else begin
          x += dx; y -= dy; z += atan_step(i);
        end
      end
      c = sat_one(neg ? -x : x);
      s = sat_one(neg ? -y : y);
      t = Q30 - c;
      p = fx_mul(ux, ux); e[0] = p + fx_mul(Q30 - p, c);
      p = fx_mul(uy, uy); e[4] = p + fx_mul(Q30 - p, c);
      p = fx_mul(uz, uz); e[8] = p + fx_mul(Q30 - p, c);
      p = fx_mul(fx_mul(ux, uy), t);
      e[1] = p - fx_mul(uz, s); e[3] = p + fx_mul(uz, s);
      p = fx_mul(fx_mul(ux, uz), t);
      e[2] = p + fx_mul(uy, s); e[6] = p - fx_mul(uy, s);
      p = fx_mul(fx_mul(uy, uz), t);
      e[5] = p - fx_mul(ux, s); e[7] = p + fx_mul(ux, s);
    end
    for (int i = 0; i < 9; i++) o.m[i] = 32'(rnd_away(sat_one(e[i]), 30 - FRAC_BITS));
    o.zero = (s2 == 0);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic rot_req_t rand_req();
    rot_req_t r;
    r.ang = ($urandom_range(0, 3) == 0) ? $urandom : rand_field();
    r.ax = rand_field();
    r.ay = rand_field();
    r.az = ($urandom_range(0, 30) == 0) ? 32'h0 : rand_field();
    if ($urandom_range(0, 40) == 0) begin
      r.ax = 0; r.ay = 0; r.az = 0;
    end
    return r;
  endfunction

  function automatic logic ready_pattern();
    case ($urandom_range(0, 3))
      0: return 1'b1;
      1: return ($urandom_range(0, 3) != 0);
      2: return 1'($urandom_range(0, 1));
      default: return ($urandom_range(0, 7) == 0);
    endcase
  endfunction

  task automatic send_beat(rot_req_t rq);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= rq;
    do @(posedge clk); while (!in_tready);
    mat_q.push_back(rotation_matrix(rq));
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  // identity rows for zero axis; other rows, such as +-90/180 deg about unit axes, checked by predictor
  stim_row_t rows[$];

  task automatic add_row(logic [31:0] a, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         bit typed);
    stim_row_t s;
    s.req = '{az: z, ay: y, ax: x, ang: a};
    s.typed = typed;
    s.mat.m = '0;
    s.mat.m[0] = 32'h4000_0000;
    s.mat.m[4] = 32'h4000_0000;
    s.mat.m[8] = 32'h4000_0000;
    s.mat.zero = 1'b1;
    rows.push_back(s);
  endtask

  initial begin
    rot_req_t rq;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    errors = 0;
    send_done = 0;
    add_row(32'h0, 32'h0, 32'h0, 32'h0, 1);
    add_row(32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 1);
    add_row(32'h8000_0000, 32'h0, 32'h0, 32'h0, 1);
    add_row(32'h005a_0000, 32'h0001_0000, 32'h0, 32'h0, 0);
    add_row(32'h005a_0000, 32'h0, 32'h0001_0000, 32'h0, 0);
    add_row(32'h005a_0000, 32'h0, 32'h0, 32'h0001_0000, 0);
    add_row(32'h00b4_0000, 32'h0, 32'h0, 32'h0001_0000, 0);
    add_row(32'hff4c_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
    add_row(32'h0168_0000, 32'h0, 32'h0001_0000, 32'h0, 0);
    add_row(32'hffa6_0000, 32'h0, 32'h0001_0000, 32'h0, 0);
    add_row(32'h005a_0001, 32'h0000_0001, 32'h0, 32'h0, 0);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 0);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 0);
    add_row(32'h0087_0000, 32'h0003_0000, 32'hfffc_0000, 32'h0000_8000, 0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      in_tvalid <= 1'b1;
      in_tdata <= rows[i].req;
      do @(posedge clk); while (!in_tready);
      mat_q.push_back(rows[i].typed ? rows[i].mat : rotation_matrix(rows[i].req));
    end
    in_tvalid <= 1'b0;
    wait (mat_q.size() == 0);
    @(posedge clk);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        wait (mat_q.size() == 0);
        @(posedge clk);
      end
      rq = rand_req();
      send_beat(rq);
    end
    in_tvalid <= 1'b0;
    send_done = 1;
  end

  // random stalls, then a long hold while the sender keeps offering beats, then random stalls again
  initial begin
    int hold;
    out_tready = 1'b0;
    wait (rst_n);
    repeat (400) begin
      @(posedge clk);
      out_tready <= ready_pattern();
    end
    @(posedge clk);
    out_tready <= 1'b0;
    hold = 0;
    while (hold < 300) begin
      @(posedge clk);
      hold++;
    end
    forever begin
      @(posedge clk);
      out_tready <= ready_pattern();
    end
  end

  always @(posedge clk) begin
    rot_mat_t ex;
    if (rst_n && out_tvalid && out_tready) begin
      if (mat_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], 32'h0);
      end else begin
        ex = mat_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_tdata[32*i +: 32] !== ex.m[i])
            report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                            out_tdata[32*i +: 32], ex.m[i]);
        if (out_tuser !== ex.zero)
          report_mismatch("zero_axis", 32'(out_tuser), 32'(ex.zero));
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    wait (send_done);
    wait (mat_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && mat_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
